// File: rtl/core/rfob_pkg.sv
// shared types and constants of the raster fill / outline / alpha blit engine
// no dependencies
`default_nettype none

package rfob_pkg;

    localparam int CW     = 11;
    localparam int ADDR_W = 20;
    localparam int Q_DEPTH = 4;
    localparam int QI_W   = 2;

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_FILL    = 3'd1;
    localparam logic [2:0] OP_OUTLINE = 3'd2;
    localparam logic [2:0] OP_SPR_START = 3'd3;
    localparam logic [2:0] OP_SPR_PIX = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        K_BOX   = 2'd0,
        K_BLEND = 2'd1,
        K_READ  = 2'd2,
        K_ZERO  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               outline;
        logic [CW-1:0]      x0;
        logic [CW-1:0]      y0;
        logic [CW-1:0]      x1;
        logic [CW-1:0]      y1;
        logic signed [CW:0] bx0;
        logic signed [CW:0] bx1;
        logic signed [CW:0] by0;
        logic signed [CW:0] by1;
        logic [31:0]        color;
        logic [ADDR_W-1:0]  addr;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

endpackage

`default_nettype wire

// File: rtl/core/raster_fill_outline_alpha_blit.sv
// top level of the 2d raster engine: clear, fill, outline, alpha sprite blit, read back
// front accepts up to one command per cycle into a 4-entry queue while it is not full; back drains it
// clear/fill/outline: the box walker visits every clipped pixel, row by row
// sprite pixel: back steps store read, multiply, then divide and write (S_BRD, S_BMUL, S_BWR)
// read: the store word passes r_rdata, then r_pixel with o_out_valid; off frame, zero is loaded into r_pixel on pop
// reset clears control and sprite state; the store holds garbage until cleared or written
`default_nettype none

module raster_fill_outline_alpha_blit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_opcode,
    input  wire logic signed [10:0] i_left,
    input  wire logic signed [10:0] i_top,
    input  wire logic signed [10:0] i_right,
    input  wire logic signed [10:0] i_bottom,
    input  wire logic [31:0]        i_color,
    input  wire logic [7:0]         i_thickness,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [31:0]             o_pixel,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [8:0]         i_cfg_data
);
    import rfob_pkg::*;

    t_cmd   push_cmd, head_cmd;
    t_qstat qstat;
    logic   push, pop, accept;

    assign o_in_stall = qstat.full;
    assign accept     = i_in_valid && !qstat.full;

    rfob_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_left      (i_left),
        .i_top       (i_top),
        .i_right     (i_right),
        .i_bottom    (i_bottom),
        .i_color     (i_color),
        .i_thickness (i_thickness),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    rfob_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (qstat)
    );

    rfob_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel     (o_pixel)
    );

endmodule

`default_nettype wire

// File: rtl/core/rfob_queue.sv
// short command queue between front and back
// depends on rfob_pkg
`default_nettype none

module rfob_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  rfob_pkg::t_cmd     i_cmd,
    input  wire logic          i_pop,
    output rfob_pkg::t_cmd     o_cmd,
    output rfob_pkg::t_qstat   o_stat
);
    import rfob_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [QI_W-1:0] r_wp;
    logic [QI_W-1:0] r_rp;
    logic [QI_W:0]   r_cnt;

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == (QI_W+1)'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rfob_front.sv
// front end: config registers, clipping, sprite stream tracking, command decode
// depends on rfob_pkg
`default_nettype none

module rfob_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [2:0]           i_opcode,
    input  wire logic signed [10:0]   i_left,
    input  wire logic signed [10:0]   i_top,
    input  wire logic signed [10:0]   i_right,
    input  wire logic signed [10:0]   i_bottom,
    input  wire logic [31:0]          i_color,
    input  wire logic [7:0]           i_thickness,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_index,
    input  wire logic [8:0]           i_cfg_data,
    output logic                      o_cfg_ready,
    output logic                      o_push,
    output rfob_pkg::t_cmd            o_cmd
);
    import rfob_pkg::*;

    localparam logic [CW-1:0] MW = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] MH = CW'(MAX_HEIGHT);

    logic [8:0]           r_fw;
    logic [8:0]           r_fh;
    logic signed [CW-1:0] r_sl, r_st, r_sr, r_sb;
    logic [CW-1:0]        r_col, r_row;

    logic [CW-1:0]        vw, vh;
    logic signed [CW:0]   bl, bt, br, bb, cl, ct, cr, cb, th;
    logic                 empty;
    logic signed [CW:0]   sw, sh;
    logic signed [CW+1:0] sx, sy, rx, ry;
    logic                 take, s_in, r_in;
    logic [CW-1:0]        col_next;
    logic                 wrap;
    logic [ADDR_W-1:0]    box_addr, spr_addr, rd_addr;

    assign o_cfg_ready = 1'b1;

    assign vw = ({2'b0, r_fw} > MW) ? MW : {2'b0, r_fw};
    assign vh = ({2'b0, r_fh} > MH) ? MH : {2'b0, r_fh};

    always_comb begin
        if (i_opcode == OP_CLEAR) begin
            bl = '0;
            bt = '0;
            br = {1'b0, vw};
            bb = {1'b0, vh};
        end else begin
            bl = {i_left[10], i_left};
            bt = {i_top[10], i_top};
            br = {i_right[10], i_right};
            bb = {i_bottom[10], i_bottom};
        end
        cl = (bl < 0) ? '0 : bl;
        ct = (bt < 0) ? '0 : bt;
        cr = (br > $signed({1'b0, vw})) ? $signed({1'b0, vw}) : br;
        cb = (bb > $signed({1'b0, vh})) ? $signed({1'b0, vh}) : bb;
        empty = (cr <= cl) || (cb <= ct);
        th = $signed({4'b0, i_thickness});
        box_addr = ADDR_W'(ct[CW-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cl[CW-1:0]);
    end

    always_comb begin
        sw   = {r_sr[10], r_sr} - {r_sl[10], r_sl};
        sh   = {r_sb[10], r_sb} - {r_st[10], r_st};
        take = (sw > 0) && (sh > 0) && ($signed({1'b0, r_row}) < sh);
        sx   = {{2{r_sl[10]}}, r_sl} + $signed({2'b0, r_col});
        sy   = {{2{r_st[10]}}, r_st} + $signed({2'b0, r_row});
        s_in = (sx >= 0) && (sy >= 0) && (sx < $signed({2'b0, vw}))
               && (sy < $signed({2'b0, vh}));
        col_next = r_col + 1'b1;
        wrap = ($signed({1'b0, col_next}) >= sw);
        spr_addr = ADDR_W'(sy[CW-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx[CW-1:0]);
        rx   = {{2{i_left[10]}}, i_left};
        ry   = {{2{i_top[10]}}, i_top};
        r_in = (rx >= 0) && (ry >= 0) && (rx < $signed({2'b0, vw}))
               && (ry < $signed({2'b0, vh}));
        rd_addr = ADDR_W'(ry[CW-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rx[CW-1:0]);
    end

    always_comb begin
        o_cmd.kind    = K_BOX;
        o_cmd.outline = (i_opcode == OP_OUTLINE);
        o_cmd.x0      = cl[CW-1:0];
        o_cmd.y0      = ct[CW-1:0];
        o_cmd.x1      = cr[CW-1:0];
        o_cmd.y1      = cb[CW-1:0];
        o_cmd.bx0     = cl + th;
        o_cmd.bx1     = cr - th - (CW+1)'(1);
        o_cmd.by0     = ct + th;
        o_cmd.by1     = cb - th - (CW+1)'(1);
        o_cmd.color   = i_color;
        o_cmd.addr    = box_addr;
        o_push        = 1'b0;
        case (i_opcode)
            OP_CLEAR, OP_FILL, OP_OUTLINE: begin
                o_push = i_accept && !empty;
            end
            OP_SPR_PIX: begin
                o_cmd.kind = K_BLEND;
                o_cmd.addr = spr_addr;
                o_push     = i_accept && take && s_in;
            end
            OP_READ: begin
                o_cmd.kind = r_in ? K_READ : K_ZERO;
                o_cmd.addr = rd_addr;
                o_push     = i_accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= 9'd256;
            r_fh  <= 9'd256;
            r_sl  <= '0;
            r_st  <= '0;
            r_sr  <= '0;
            r_sb  <= '0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_fw <= i_cfg_data;
                end else begin
                    r_fh <= i_cfg_data;
                end
            end
            if (i_accept && i_opcode == OP_SPR_START) begin
                r_sl  <= i_left;
                r_st  <= i_top;
                r_sr  <= i_right;
                r_sb  <= i_bottom;
                r_col <= '0;
                r_row <= '0;
            end else if (i_accept && i_opcode == OP_SPR_PIX && take) begin
                if (wrap) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= col_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rfob_back.sv
// back end: framebuffer store, box walker, blend pipeline, read-back register
// depends on rfob_pkg
`default_nettype none

module rfob_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  rfob_pkg::t_qstat i_qstat,
    input  rfob_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_pixel
);
    import rfob_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_BRD  = 6'b000100,
        S_BMUL = 6'b001000,
        S_BWR  = 6'b010000,
        S_RRD  = 6'b100000
    } t_state;

    logic [31:0]       mem [DEPTH];
    t_state            r_state;
    t_cmd              r_cmd;
    logic [CW-1:0]     r_x, r_y;
    logic [ADDR_W-1:0] r_addr, r_row;
    logic [31:0]       r_rdata;
    logic [15:0]       r_prod [3];
    logic              r_rd_done;
    logic              r_out_valid;
    logic [31:0]       r_pixel;

    logic              we;
    logic [31:0]       wd;
    logic              band;
    logic [7:0]        alpha;
    logic [7:0]        chan [3];
    logic [15:0]       fix [3];
    logic              last_x, last_y;

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_pixel;
    assign alpha       = r_cmd.color[31:24];

    assign o_pop = (r_state == S_IDLE) && !r_rd_done && i_qstat.valid
                   && ((i_cmd.kind != K_READ && i_cmd.kind != K_ZERO) || !r_out_valid);

    always_comb begin
        band = !r_cmd.outline
               || ($signed({1'b0, r_x}) <= r_cmd.bx0)
               || ($signed({1'b0, r_x}) >= r_cmd.bx1)
               || ($signed({1'b0, r_y}) <= r_cmd.by0)
               || ($signed({1'b0, r_y}) >= r_cmd.by1);
        last_x = (r_x + 1'b1) == r_cmd.x1;
        last_y = (r_y + 1'b1) == r_cmd.y1;
        for (int i = 0; i < 3; i++) begin
            fix[i]  = r_prod[i] + 16'd1 + (r_prod[i] >> 8);
            chan[i] = fix[i][15:8];
        end
        we = 1'b0;
        wd = r_cmd.color;
        case (r_state)
            S_WALK: begin
                we = band;
            end
            S_BWR: begin
                we = 1'b1;
                wd = {8'hff, chan[2], chan[1], chan[0]};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_addr[AW-1:0]] <= wd;
        end
        r_rdata <= mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_prod[i] <= 16'(r_rdata[8*i +: 8]) * 16'(8'hff - alpha)
                       + 16'(r_cmd.color[8*i +: 8]) * 16'(alpha);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_x    <= i_cmd.x0;
            r_y    <= i_cmd.y0;
            r_addr <= i_cmd.addr;
            r_row  <= i_cmd.addr;
        end else if (r_state == S_WALK) begin
            if (last_x) begin
                r_x    <= r_cmd.x0;
                r_y    <= r_y + 1'b1;
                r_row  <= r_row + ADDR_W'(MAX_WIDTH);
                r_addr <= r_row + ADDR_W'(MAX_WIDTH);
            end else begin
                r_x    <= r_x + 1'b1;
                r_addr <= r_addr + 1'b1;
            end
        end
        if (r_rd_done) begin
            r_pixel <= r_rdata;
        end else if (o_pop && i_cmd.kind == K_ZERO) begin
            r_pixel <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_done   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_done <= (r_state == S_RRD);
            if (r_rd_done || (o_pop && i_cmd.kind == K_ZERO)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.kind)
                            K_BOX:   r_state <= S_WALK;
                            K_BLEND: r_state <= S_BRD;
                            K_READ:  r_state <= S_RRD;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WALK: begin
                    if (last_x && last_y) begin
                        r_state <= S_IDLE;
                    end
                end
                S_BRD:   r_state <= S_BMUL;
                S_BMUL:  r_state <= S_BWR;
                S_BWR:   r_state <= S_IDLE;
                S_RRD:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_WALK || r_state == S_BWR))
        else $error("store write outside walk or blend write");

    a_rd_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_done |-> !r_out_valid)
        else $error("read data arrives while output register busy");

    a_blend_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BMUL) |-> $past(r_state) == S_BRD)
        else $error("blend multiply without preceding read");

endmodule

`default_nettype wire

// File: verif/tb_raster_fill_outline_alpha_blit.sv
// self-checking testbench for the raster fill / outline / alpha blit engine
// predicts the framebuffer in a local array and checks every read-back beat in order
// depends on rfob_pkg and raster_fill_outline_alpha_blit
`default_nettype none

module tb_raster_fill_outline_alpha_blit;
    import rfob_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int FB_W = 256;
    localparam int FB_H = 256;

    typedef struct {
        logic [2:0]         op;
        logic signed [10:0] l;
        logic signed [10:0] t;
        logic signed [10:0] r;
        logic signed [10:0] b;
        logic [31:0]        color;
        logic [7:0]         th;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [2:0] i_opcode = '0;
    logic signed [10:0] i_left = '0;
    logic signed [10:0] i_top = '0;
    logic signed [10:0] i_right = '0;
    logic signed [10:0] i_bottom = '0;
    logic [31:0] i_color = '0;
    logic [7:0] i_thickness = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [31:0] o_pixel;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = 1'b0;
    logic [8:0] i_cfg_data = '0;

    raster_fill_outline_alpha_blit dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [31:0] fb_words [FB_W*FB_H];
    int vis_w = 256;
    int vis_h = 256;
    int spr_l = 0, spr_t = 0, spr_r = 0, spr_b = 0, spr_col = 0, spr_row = 0;

    t_beat       pending_beats[$];
    logic [31:0] expected_pixels[$];
    int fail_count = 0;
    int reads_checked = 0;
    int beats_sent = 0;
    int idle_mode = 0;
    bit hold_go = 1'b0;
    int hold_count = 0;

    function automatic logic [31:0] blend_argb(logic [31:0] dst, logic [31:0] src);
        int a;
        logic [31:0] res;
        a = src[31:24];
        res = 32'hff00_0000;
        for (int sh = 0; sh <= 16; sh += 8) begin
            res[sh +: 8] = 8'((int'(dst[sh +: 8]) * (255 - a) + int'(src[sh +: 8]) * a) / 255);
        end
        return res;
    endfunction

    function automatic bit on_frame(int x, int y);
        return x >= 0 && y >= 0 && x < vis_w && y < vis_h;
    endfunction

    function automatic void paint_box(int l, int t, int r, int b, logic [31:0] col,
                                      bit outline, int th);
        if (l < 0) l = 0;
        if (t < 0) t = 0;
        if (r > vis_w) r = vis_w;
        if (b > vis_h) b = vis_h;
        for (int y = t; y < b; y++) begin
            for (int x = l; x < r; x++) begin
                if (!outline || x <= l + th || x >= r - th - 1 ||
                    y <= t + th || y >= b - th - 1)
                    fb_words[y*FB_W + x] = col;
            end
        end
    endfunction

    function automatic void predict_beat(t_beat bt);
        int l, t, r, b, x, y;
        l = bt.l;
        t = bt.t;
        r = bt.r;
        b = bt.b;
        case (bt.op)
            OP_CLEAR: paint_box(0, 0, vis_w, vis_h, bt.color, 1'b0, 0);
            OP_FILL: paint_box(l, t, r, b, bt.color, 1'b0, 0);
            OP_OUTLINE: paint_box(l, t, r, b, bt.color, 1'b1, int'(bt.th));
            OP_SPR_START: begin
                spr_l = l; spr_t = t; spr_r = r; spr_b = b;
                spr_col = 0; spr_row = 0;
            end
            OP_SPR_PIX: begin
                if (spr_r - spr_l > 0 && spr_b - spr_t > 0 && spr_row < spr_b - spr_t) begin
                    x = spr_l + spr_col;
                    y = spr_t + spr_row;
                    if (on_frame(x, y))
                        fb_words[y*FB_W + x] = blend_argb(fb_words[y*FB_W + x], bt.color);
                    spr_col++;
                    if (spr_col >= spr_r - spr_l) begin
                        spr_col = 0;
                        spr_row++;
                    end
                end
            end
            OP_READ: expected_pixels.push_back(on_frame(l, t) ? fb_words[t*FB_W + l] : 32'd0);
            default: ;
        endcase
    endfunction

    // driver and input monitor
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            predict_beat('{i_opcode, i_left, i_top, i_right, i_bottom, i_color, i_thickness});
            beats_sent++;
        end
        if (!i_in_valid || !o_in_stall) begin
            if (pending_beats.size() > 0 && i_rst_n &&
                !(idle_mode == 0 && $urandom_range(0, 99) < 20) &&
                !(idle_mode == 1 && $urandom_range(0, 99) < 86)) begin
                i_opcode    <= pending_beats[0].op;
                i_left      <= pending_beats[0].l;
                i_top       <= pending_beats[0].t;
                i_right     <= pending_beats[0].r;
                i_bottom    <= pending_beats[0].b;
                i_color     <= pending_beats[0].color;
                i_thickness <= pending_beats[0].th;
                i_in_valid  <= 1'b1;
                void'(pending_beats.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result stall, with one long hold-off
    always @(posedge i_clk) begin
        if (hold_go && hold_count < 400) begin
            hold_count <= hold_count + 1;
            i_out_stall <= 1'b1;
        end else if (idle_mode == 0) begin
            i_out_stall <= $urandom_range(0, 99) < 86;
        end else if (idle_mode == 1) begin
            i_out_stall <= $urandom_range(0, 99) < 20;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("pixel beat with nothing expected: actual %h", o_pixel);
                fail_count++;
            end else begin
                if (o_pixel !== expected_pixels[0]) begin
                    $error("pixel mismatch: expected %h actual %h", expected_pixels[0], o_pixel);
                    fail_count++;
                end
                void'(expected_pixels.pop_front());
                reads_checked++;
            end
        end
    end

    task automatic push_beat(logic [2:0] op, int l, int t, int r, int b,
                             logic [31:0] col, int th);
        t_beat bt;
        bt.op = op; bt.l = 11'(l); bt.t = 11'(t); bt.r = 11'(r); bt.b = 11'(b);
        bt.color = col; bt.th = 8'(th);
        pending_beats.push_back(bt);
    endtask

    task automatic drain();
        push_beat(OP_READ, 0, 0, 0, 0, 32'd0, 0);
        while (pending_beats.size() > 0 || i_in_valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[8:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH)
            vis_w = (val[8:0] < FB_W) ? val[8:0] : FB_W;
        else
            vis_h = (val[8:0] < FB_H) ? val[8:0] : FB_H;
    endtask

    function automatic int rand_coord(int span);
        if ($urandom_range(0, 9) == 0)
            return $signed(11'($urandom));
        return int'($urandom_range(0, span + 8)) - 4;
    endfunction

    task automatic push_random();
        int pick, w, h, n;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            push_beat(OP_CLEAR, 0, 0, 0, 0, $urandom, 0);
        end else if (pick < 19) begin
            push_beat(OP_FILL, rand_coord(vis_w), rand_coord(vis_h), rand_coord(vis_w),
                      rand_coord(vis_h), $urandom, $urandom_range(0, 255));
        end else if (pick < 34) begin
            push_beat(OP_OUTLINE, rand_coord(vis_w), rand_coord(vis_h), rand_coord(vis_w),
                      rand_coord(vis_h), $urandom,
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 4));
        end else if (pick < 60) begin
            w = $urandom_range(0, 9) == 0 ? -$urandom_range(0, 2) : $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            push_beat(OP_SPR_START, rand_coord(vis_w), rand_coord(vis_h), 0, 0, 0, 0);
            pending_beats[$].r = 11'(pending_beats[$].l + w);
            pending_beats[$].b = 11'(pending_beats[$].t + h);
            n = (w > 0 ? w * h : 2) + $urandom_range(0, 2) - 1;
            for (int i = 0; i < n; i++)
                push_beat(OP_SPR_PIX, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            push_beat(OP_READ, rand_coord(vis_w), rand_coord(vis_h), 0, 0, 0, 0);
        end else if (pick < 94) begin
            push_beat(OP_READ, rand_coord(vis_w), rand_coord(vis_h), $urandom, $urandom,
                      $urandom, $urandom);
        end else begin
            push_beat($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        #(20 * 3_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(CFG_WIDTH, 256);
        write_cfg(CFG_HEIGHT, 256);
        // directed: full frame, clipping, band, blend alpha extremes, spare opcodes
        push_beat(OP_CLEAR, 0, 0, 0, 0, 32'h1234_5678, 0);
        push_beat(OP_FILL, -1024, -1024, 1023, 1023, 32'hffff_ffff, 0);
        push_beat(OP_READ, 0, 0, 0, 0, 0, 0);
        push_beat(OP_READ, 255, 255, 0, 0, 0, 0);
        push_beat(OP_READ, 256, 0, 0, 0, 0, 0);
        push_beat(OP_READ, -1, -1, 0, 0, 0, 0);
        push_beat(OP_READ, -1024, 1023, 0, 0, 0, 0);
        push_beat(OP_OUTLINE, -1024, -1024, 1023, 1023, 32'h00a5_5a00, 255);
        push_beat(OP_OUTLINE, 10, 10, 30, 25, 32'h8000_00ff, 0);
        push_beat(OP_READ, 10, 12, 0, 0, 0, 0);
        push_beat(OP_READ, 15, 15, 0, 0, 0, 0);
        push_beat(OP_READ, 29, 24, 0, 0, 0, 0);
        push_beat(OP_FILL, 40, 40, 30, 50, 32'h0, 0);
        push_beat(OP_SPR_START, 254, 254, 258, 256, 0, 0);
        for (int i = 0; i < 9; i++)
            push_beat(OP_SPR_PIX, 0, 0, 0, 0, i % 3 == 0 ? 32'h00ff_ffff :
                      i % 3 == 1 ? 32'hff00_ff00 : 32'h80ff_0080, 0);
        push_beat(OP_READ, 254, 254, 0, 0, 0, 0);
        push_beat(OP_READ, 255, 255, 0, 0, 0, 0);
        push_beat(OP_SPR_START, 5, 5, 5, 9, 0, 0);
        push_beat(OP_SPR_PIX, 0, 0, 0, 0, 32'hffff_ffff, 0);
        push_beat(OP_SPARE_A, 0, 0, 0, 0, 0, 0);
        push_beat(OP_SPARE_B, -1, -1, -1, -1, 32'hffff_ffff, 255);
        push_beat(OP_READ, 5, 5, 0, 0, 0, 0);
        drain();
        write_cfg(CFG_WIDTH, 1);
        write_cfg(CFG_HEIGHT, 1);
        push_beat(OP_FILL, -5, -5, 5, 5, 32'hdead_beef, 0);
        push_beat(OP_READ, 0, 0, 0, 0, 0, 0);
        push_beat(OP_READ, 1, 0, 0, 0, 0, 0);
        push_beat(OP_READ, 0, 1, 0, 0, 0, 0);
        drain();
        for (int m = 0; m < 3; m++) begin
            idle_mode = m;
            for (int blk = 0; blk < 3; blk++) begin
                write_cfg(CFG_WIDTH, $urandom_range(1, 9) == 1 ? 256 : $urandom_range(1, 48));
                write_cfg(CFG_HEIGHT, $urandom_range(1, 48));
                if (m == 2 && blk == 0) begin
                    hold_go = 1'b1;
                    for (int i = 0; i < 30; i++)
                        push_beat(OP_READ, rand_coord(vis_w), rand_coord(vis_h), 0, 0, 0, 0);
                end
                for (int i = 0; i < 22; i++)
                    push_random();
                drain();
            end
        end
        repeat (30) @(posedge i_clk);
        $display("covered %0d beats with %0d read-backs checked over clear, fill, outline,",
                 beats_sent, reads_checked);
        $display("sprite blend and spare opcodes across several frame sizes");
        if (fail_count == 0 && expected_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/core/rfob_pkg.sv
rtl/core/rfob_queue.sv
rtl/core/rfob_front.sv
rtl/core/rfob_back.sv
rtl/core/raster_fill_outline_alpha_blit.sv
verif/tb_raster_fill_outline_alpha_blit.sv
